@@ rtl/core/ngga_pkg.sv @@
// ----------------------------------------------------------------------------
// ngga_pkg
// Shared types, character codes and helpers for the GGA time/position parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ngga_pkg;

  // Character codes
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SOUTH = 8'h53;
  localparam logic [7:0] CHAR_WEST  = 8'h57;

  // Field numbers within the sentence
  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;

  // Minimum field count and lengths for a valid decode
  localparam logic [3:0] POS_MIN_FIELDS = 4'd5;
  localparam logic [3:0] TIME_MIN_LEN   = 4'd6;
  localparam logic [3:0] LAT_MIN_LEN    = 4'd4;
  localparam logic [3:0] LON_MIN_LEN    = 4'd5;

  // Digit subfield slots
  localparam int SLOT_HH      = 0;
  localparam int SLOT_MM      = 1;
  localparam int SLOT_SS      = 2;
  localparam int SLOT_TFRAC   = 3;
  localparam int SLOT_LAT_DEG = 4;
  localparam int SLOT_LAT_MIN = 5;
  localparam int SLOT_LAT_FRC = 6;
  localparam int SLOT_LON_DEG = 7;
  localparam int SLOT_LON_MIN = 8;
  localparam int SLOT_LON_FRC = 9;
  localparam int SLOT_COUNT   = 10;

  // Sentence state gathered character by character
  typedef struct packed {
    logic [3:0]  field_index;
    logic [3:0]  time_len;
    logic [6:0]  hh;
    logic [6:0]  mm;
    logic [6:0]  ss;
    logic [9:0]  tfrac;
    logic [3:0]  lat_len;
    logic [6:0]  lat_deg;
    logic [6:0]  lat_min;
    logic [13:0] lat_frac;
    logic [3:0]  lon_len;
    logic [9:0]  lon_deg;
    logic [6:0]  lon_min;
    logic [13:0] lon_frac;
    logic        hem_south;
    logic        hem_west;
  } sentence_t;

  // Partial products between snapshot and result
  typedef struct packed {
    logic        utc_ok;
    logic [12:0] hm;
    logic [16:0] ss_ms;
    logic [9:0]  tfrac;
    logic        lat_ok;
    logic        lat_neg;
    logic [12:0] lat_dm;
    logic [13:0] lat_frac;
    logic        lon_ok;
    logic        lon_neg;
    logic [15:0] lon_dm;
    logic [13:0] lon_frac;
  } partial_t;

  // Saturating 4-bit increment
  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    sat_inc = (v == 4'd15) ? 4'd15 : v + 4'd1;
  endfunction

  // Append one decimal digit: v*10 + d
  function automatic logic [13:0] acc_digit(input logic [13:0] v, input logic [3:0] d);
    acc_digit = (v << 3) + (v << 1) + {10'd0, d};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ngga_char_tracker.sv @@
// ----------------------------------------------------------------------------
// ngga_char_tracker
// Per-character field tracking and digit accumulation; shows the sentence
// state including the current character and clears on the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module ngga_char_tracker import ngga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       last,
  output sentence_t  snap
);

  sentence_t             sent, sent_next;
  logic [3:0]            field_length, field_length_next;
  logic [SLOT_COUNT-1:0] stopped, stopped_next;
  logic                  content_ended, content_ended_next;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [3:0]            pos;
  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] grab;

  // Decode the character against the current field and position
  always_comb begin
    sent_next          = sent;
    field_length_next  = field_length;
    content_ended_next = content_ended;
    hit                = '0;
    is_digit           = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    digit              = char_code[3:0];
    pos                = field_length;
    if (!content_ended) begin
      if (char_code == CHAR_STAR) begin
        content_ended_next = 1'b1;
      end else if (char_code == CHAR_COMMA) begin
        sent_next.field_index = sat_inc(sent.field_index);
        field_length_next     = '0;
      end else begin
        case (sent.field_index)
          FLD_TIME: begin
            sent_next.time_len = sat_inc(sent.time_len);
            if (pos < 4'd2) hit[SLOT_HH] = 1'b1;
            else if (pos < 4'd4) hit[SLOT_MM] = 1'b1;
            else if (pos < 4'd6) hit[SLOT_SS] = 1'b1;
            else if (pos >= 4'd7 && pos <= 4'd9) hit[SLOT_TFRAC] = 1'b1;
          end
          FLD_LAT: begin
            sent_next.lat_len = sat_inc(sent.lat_len);
            if (pos < 4'd2) hit[SLOT_LAT_DEG] = 1'b1;
            else if (pos < 4'd4) hit[SLOT_LAT_MIN] = 1'b1;
            else if (pos >= 4'd5 && pos <= 4'd8) hit[SLOT_LAT_FRC] = 1'b1;
          end
          FLD_NS: begin
            if (pos == 4'd0) sent_next.hem_south = (char_code == CHAR_SOUTH);
          end
          FLD_LON: begin
            sent_next.lon_len = sat_inc(sent.lon_len);
            if (pos < 4'd3) hit[SLOT_LON_DEG] = 1'b1;
            else if (pos < 4'd5) hit[SLOT_LON_MIN] = 1'b1;
            else if (pos >= 4'd6 && pos <= 4'd9) hit[SLOT_LON_FRC] = 1'b1;
          end
          FLD_EW: begin
            if (pos == 4'd0) sent_next.hem_west = (char_code == CHAR_WEST);
          end
          default: begin
          end
        endcase
        field_length_next = sat_inc(field_length);
      end
    end

    // A non-digit stops its subfield for good
    grab         = hit & ~stopped & {SLOT_COUNT{is_digit}};
    stopped_next = stopped | (hit & ~stopped & {SLOT_COUNT{~is_digit}});

    if (grab[SLOT_HH])      sent_next.hh       = 7'(acc_digit(14'(sent.hh), digit));
    if (grab[SLOT_MM])      sent_next.mm       = 7'(acc_digit(14'(sent.mm), digit));
    if (grab[SLOT_SS])      sent_next.ss       = 7'(acc_digit(14'(sent.ss), digit));
    if (grab[SLOT_TFRAC])   sent_next.tfrac    = 10'(acc_digit(14'(sent.tfrac), digit));
    if (grab[SLOT_LAT_DEG]) sent_next.lat_deg  = 7'(acc_digit(14'(sent.lat_deg), digit));
    if (grab[SLOT_LAT_MIN]) sent_next.lat_min  = 7'(acc_digit(14'(sent.lat_min), digit));
    if (grab[SLOT_LAT_FRC]) sent_next.lat_frac = acc_digit(sent.lat_frac, digit);
    if (grab[SLOT_LON_DEG]) sent_next.lon_deg  = 10'(acc_digit(14'(sent.lon_deg), digit));
    if (grab[SLOT_LON_MIN]) sent_next.lon_min  = 7'(acc_digit(14'(sent.lon_min), digit));
    if (grab[SLOT_LON_FRC]) sent_next.lon_frac = acc_digit(sent.lon_frac, digit);
  end

  assign snap = sent_next;

  // Advance on each transaction; clear after the last character
  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      sent          <= '0;
      field_length  <= '0;
      stopped       <= '0;
      content_ended <= 1'b0;
    end else if (take) begin
      sent          <= sent_next;
      field_length  <= field_length_next;
      stopped       <= stopped_next;
      content_ended <= content_ended_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nmea_gga_time_position_parser_top.sv @@
// ----------------------------------------------------------------------------
// nmea_gga_time_position_parser_top
// GGA sentence parser: UTC time and latitude/longitude from a character stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sentence-body character per
//   transaction in char_code, with last marking the final character. Fields
//   are comma separated; '*' ends content. Output channel (out_valid/
//   out_ready) carries one result per sentence: UTC milliseconds and latitude
//   and longitude in signed ten-thousandths of a minute, each with a valid
//   flag and zero when not valid.
//   Throughput: one character per cycle while in_ready is high, set by the
//   character tracker. After the last character is accepted, the result passes
//   through the snapshot, partial-product and result registers.
//   Reset clears all sentence state and empties the result pipeline.
//   When the receiver stalls, results are held in a three-deep register
//   chain; in_ready drops only when the snapshot stage is full and cannot
//   move, so characters keep flowing while fewer than three results wait.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_gga_time_position_parser_top import ngga_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               utc_valid,
  output logic [28:0]        utc_millis,
  output logic               lat_valid,
  output logic signed [26:0] lat_min_e4,
  output logic               lon_valid,
  output logic signed [30:0] lon_min_e4
);

  logic      accept;
  sentence_t snap;
  sentence_t s1;
  logic      s1_valid;
  partial_t  s2, s2_next;
  logic      s2_valid;
  logic      s2_load;
  logic      out_load;

  logic [28:0] ms_sum;
  logic [26:0] lat_mag;
  logic [30:0] lon_mag;

  // Pipeline flow control
  assign out_load = s2_valid && (!out_valid || out_ready);
  assign s2_load  = s1_valid && (!s2_valid || out_load);
  assign in_ready = !s1_valid || s2_load;
  assign accept   = in_valid && in_ready;

  ngga_char_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .take      (accept),
    .char_code (char_code),
    .last      (last),
    .snap      (snap)
  );

  // Snapshot the finished sentence
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && last) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      s1 <= snap;
    end
  end

  // Form validity, minute sums and padded fractions
  always_comb begin
    s2_next.utc_ok  = (s1.field_index >= FLD_TIME) && (s1.time_len >= TIME_MIN_LEN);
    s2_next.lat_ok  = (s1.field_index >= POS_MIN_FIELDS) && (s1.lat_len >= LAT_MIN_LEN);
    s2_next.lon_ok  = (s1.field_index >= POS_MIN_FIELDS) && (s1.lon_len >= LON_MIN_LEN);
    s2_next.lat_neg = s2_next.lat_ok && s1.hem_south;
    s2_next.lon_neg = s2_next.lon_ok && s1.hem_west;
    s2_next.hm      = 13'(13'(s1.hh) * 13'd60 + 13'(s1.mm));
    s2_next.ss_ms   = 17'(17'(s1.ss) * 17'd1000);
    s2_next.lat_dm  = 13'(13'(s1.lat_deg) * 13'd60 + 13'(s1.lat_min));
    s2_next.lon_dm  = 16'(16'(s1.lon_deg) * 16'd60 + 16'(s1.lon_min));

    // Right-pad the fractions by the field length
    if (s1.time_len == 4'd8)      s2_next.tfrac = 10'(s1.tfrac * 10'd100);
    else if (s1.time_len == 4'd9) s2_next.tfrac = 10'(s1.tfrac * 10'd10);
    else if (s1.time_len >= 4'd10) s2_next.tfrac = s1.tfrac;
    else                          s2_next.tfrac = '0;

    if (s1.lat_len == 4'd6)       s2_next.lat_frac = 14'(s1.lat_frac * 14'd1000);
    else if (s1.lat_len == 4'd7)  s2_next.lat_frac = 14'(s1.lat_frac * 14'd100);
    else if (s1.lat_len == 4'd8)  s2_next.lat_frac = 14'(s1.lat_frac * 14'd10);
    else if (s1.lat_len >= 4'd9)  s2_next.lat_frac = s1.lat_frac;
    else                          s2_next.lat_frac = '0;

    if (s1.lon_len == 4'd7)       s2_next.lon_frac = 14'(s1.lon_frac * 14'd1000);
    else if (s1.lon_len == 4'd8)  s2_next.lon_frac = 14'(s1.lon_frac * 14'd100);
    else if (s1.lon_len == 4'd9)  s2_next.lon_frac = 14'(s1.lon_frac * 14'd10);
    else if (s1.lon_len >= 4'd10) s2_next.lon_frac = s1.lon_frac;
    else                          s2_next.lon_frac = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (out_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2 <= s2_next;
    end
  end

  // Scale to final units and apply hemisphere sign
  assign ms_sum  = 29'(29'(s2.hm) * 29'd60000) + 29'(s2.ss_ms) + 29'(s2.tfrac);
  assign lat_mag = 27'(27'(s2.lat_dm) * 27'd10000) + 27'(s2.lat_frac);
  assign lon_mag = 31'(31'(s2.lon_dm) * 31'd10000) + 31'(s2.lon_frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      utc_valid  <= s2.utc_ok;
      utc_millis <= s2.utc_ok ? ms_sum : '0;
      lat_valid  <= s2.lat_ok;
      lat_min_e4 <= !s2.lat_ok ? '0 :
                    s2.lat_neg ? $signed(~lat_mag + 27'd1) : $signed(lat_mag);
      lon_valid  <= s2.lon_ok;
      lon_min_e4 <= !s2.lon_ok ? '0 :
                    s2.lon_neg ? $signed(~lon_mag + 31'd1) : $signed(lon_mag);
    end
  end

  // Checks
  a_last_fills_snapshot: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> s1_valid)
    else $error("last character did not fill the snapshot stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s2_valid && out_valid && !out_ready)
    else $error("input stalled while the pipeline had room");

  a_invalid_time_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !utc_valid |-> utc_millis == '0)
    else $error("time value nonzero without a valid time");

  a_invalid_pos_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !lat_valid && !lon_valid |-> lat_min_e4 == '0 && lon_min_e4 == '0)
    else $error("position value nonzero without a valid position");

endmodule

`default_nettype wire
